FILE: rtl/sha256_byte_stream_hasher_top_assert.svh
// assertion macros for the hasher top level
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH

// condition implies consequence on the same edge
`define SHA_ASSERT_IMP(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// condition implies consequence on the following edge
`define SHA_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/sha256_pkg.sv
package sha256_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } req_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [255:0] INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/sha256_fifo.sv
// request queue between the front and the back
module sha256_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sha256_pkg::req_t   in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output sha256_pkg::req_t   out_req
);
  sha256_pkg::req_t mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic push;
  logic pop;

  assign in_stall  = (count == 3'd4);
  assign out_valid = (count != 3'd0);
  assign out_req   = mem[rd_ptr];
  assign push = in_valid && !in_stall;
  assign pop  = out_valid && !out_stall;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_req;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'd0, push} - {2'd0, pop};
    end
  end
endmodule

FILE: rtl/sha256_core.sv
// back end: block assembly, padding, compression and digest output
module sha256_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  sha256_pkg::req_t  req,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index,
  output logic              last
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]   state;
  logic [63:0]  bit_count;
  logic [511:0] blk;
  logic [255:0] chain;
  logic [255:0] work;
  logic [511:0] win;
  logic [5:0]   rnd;
  logic [5:0]   pos;
  logic         fin;
  logic [2:0]   oidx;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] w0, w1, w9, w14, s0, s1, wnew;
  logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
  logic [63:0] cnt_add;

  // schedule window, oldest word in the top slot
  assign w0  = win[511:480];
  assign w1  = win[479:448];
  assign w9  = win[223:192];
  assign w14 = win[63:32];
  assign s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign wnew = s1 + w9 + s0 + w0;

  // round datapath
  assign {a, b, c, d, e, f, g, h} = work;
  assign t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + sha256_pkg::round_k(rnd) + w0;
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  assign cnt_add = bit_count + 64'd8;

  assign pos = bit_count[8:3];
  assign req_stall = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign digest_word = chain[255 - 32 * oidx -: 32];
  assign word_index = oidx;
  assign last = (oidx == 3'd7);

  // control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bit_count <= 64'd0;
      chain     <= sha256_pkg::INIT_HASH;
      rnd       <= 6'd0;
      oidx      <= 3'd0;
      fin       <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            if (!req.req_type) begin
              blk[511 - 8 * pos -: 8] <= req.data_byte;
              bit_count <= cnt_add;
              if (pos == 6'd63) begin
                state <= ST_RND;
                fin   <= 1'b0;
                rnd   <= 6'd0;
                work  <= chain;
                win   <= {blk[511:8], req.data_byte};
              end
            end else begin
              // pad byte then zero the tail
              for (int i = 0; i < 64; i++) begin
                if (i == int'(pos)) blk[511 - 8 * i -: 8] <= sha256_pkg::PAD_BYTE;
                else if (i > int'(pos)) blk[511 - 8 * i -: 8] <= 8'd0;
              end
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          rnd   <= 6'd0;
          work  <= chain;
          state <= ST_RND;
          // length does not fit, compress the padded block first
          if (pos > 6'd55) begin
            win <= blk;
            fin <= 1'b0;
          end else begin
            win <= {blk[511:64], bit_count};
            fin <= 1'b1;
          end
        end
        ST_LEN: begin
          rnd  <= 6'd0;
          work <= chain;
          fin  <= 1'b1;
          win  <= {448'd0, bit_count};
          state <= ST_RND;
        end
        ST_RND: begin
          work <= {t1 + t2, a, b, c, d + t1, e, f, g};
          win  <= {win[479:0], wnew};
          rnd  <= rnd + 6'd1;
          if (rnd == 6'd63) state <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[255 - 32 * i -: 32] <= chain[255 - 32 * i -: 32] + work[255 - 32 * i -: 32];
          end
          if (fin) begin
            state <= ST_OUT;
            oidx  <= 3'd0;
          end else if (pos > 6'd55) begin
            state <= ST_LEN;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              state     <= ST_IDLE;
              chain     <= sha256_pkg::INIT_HASH;
              bit_count <= 64'd0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/sha256_byte_stream_hasher_top.sv
// SHA-256 over a byte stream.
// Input channel (in_valid / in_stall): req_type 0 appends data_byte to the
// message, req_type 1 pads the message and requests the digest.
// Output channel (out_valid / out_stall): eight words, word_index 0..7,
// most significant first, last high on word 7.
// A four-entry queue decouples the input handshake from the hashing core.
// An append is taken while the core is idle; the 64th byte of a block starts
// the compression (one round per cycle in ST_RND, then the chain add).
// A finish pads and compresses the last block, and compresses an extra
// length block when the length spills into one, then outputs eight words.
// Synchronous reset restores the initial hash values and a zero bit count
// and empties the queue.
// When the receiver stalls, the current digest word holds and the core
// waits; requests still fill the queue until it is full.
`include "sha256_byte_stream_hasher_top_assert.svh"
module sha256_byte_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last
);
  sha256_pkg::req_t in_req;
  sha256_pkg::req_t q_req;
  logic q_valid;
  logic q_stall;

  assign in_req.req_type  = req_type;
  assign in_req.data_byte = data_byte;

  // front queue
  sha256_fifo u_fifo (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(q_valid), .out_stall(q_stall), .out_req(q_req)
  );

  // hashing core
  sha256_core u_core (
    .clk(clk), .rst(rst),
    .req_valid(q_valid), .req_stall(q_stall), .req(q_req),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_word(digest_word), .word_index(word_index), .last(last)
  );

  // checks
  `SHA_ASSERT_IMP(a_last_idx, out_valid, last == (word_index == 3'd7))
  `SHA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(word_index))
  `SHA_ASSERT_IMP(a_core_busy, out_valid, q_stall)
endmodule
